// ===== design/clut4_texture_to_rgba_macros.svh =====
// Assertion macros shared by the CLUT4 texture decoder.
`ifndef CLUT4_TEXTURE_TO_RGBA_MACROS_SVH
`define CLUT4_TEXTURE_TO_RGBA_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLUT4_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CLUT4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/clut4_pkg.sv =====
// Package with the fixed sizes and color constants of the CLUT4 texture decoder.
package clut4_pkg;

  // Palette geometry: sixteen 16-bit colors, sent as 32 bytes.
  localparam int unsigned PalEntries = 16;
  localparam int unsigned PalAddrW   = $clog2(PalEntries);
  localparam int unsigned ColorW     = 16;
  localparam int unsigned PalBytes   = 2 * PalEntries;
  localparam int unsigned PosW       = $clog2(PalBytes) + 1;

  // Pixel format.
  localparam int unsigned RgbaW      = 32;
  localparam logic [7:0]  AlphaTrans = 8'h7F;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  typedef logic [ColorW-1:0] color_t;
  typedef logic [RgbaW-1:0]  rgba_t;

endpackage

// ===== design/clut4_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module clut4_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read ports; the data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== design/clut4_color.sv =====
// Conversion of one 15-bit palette color with its flag bit to an RGBA8888 word.
module clut4_color
  import clut4_pkg::*;
(
  input  color_t color,
  input  logic   translucency_enable,
  output rgba_t  rgba
);

  logic [4:0] red5;
  logic [4:0] green5;
  logic [4:0] blue5;
  logic [7:0] alpha;

  assign red5   = color[4:0];
  assign green5 = color[9:5];
  assign blue5  = color[14:10];

  // The flag bit selects half alpha only when translucency is switched on.
  assign alpha = (color[15] && translucency_enable) ? AlphaTrans : AlphaOpaque;

  // Each channel is widened by copying its top three bits below it.
  // A color of exactly zero is the fully transparent word.
  always_comb begin
    if (color == '0) begin
      rgba = '0;
    end else begin
      rgba = {red5, red5[4:2], green5, green5[4:2], blue5, blue5[4:2], alpha};
    end
  end

endmodule

// ===== design/clut4_texture_to_rgba.sv =====
// Top level of the CLUT4 texture decoder: palette load, lookup pipeline and result register.
//
//   channel  direction  signals                                          per transaction
//   in       input      in_data_byte, in_start_of_texture, in_end_of_texture  one raw byte
//   out      output     out_first_pixel_rgba, out_second_pixel_rgba, out_last_pair
//                                                                        one pixel pair
//   cfg      input      cfg_translucency_enable                          one register write
//
// One byte is accepted per cycle while in_ready is high. Palette bytes (the first 32 of a
// texture) load the palette RAM and give no result. An index byte reads both palette entries
// in the accept cycle; its pixel pair passes from the lookup stage into the result register.
// Reset clears the byte count, the pipeline valids and the register; palette contents
// stay undefined until loaded. A stall on out holds the pipeline and lowers in_ready
// only once both the lookup stage and the result register are full.
module clut4_texture_to_rgba
  import clut4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_texture,
  input  logic       in_end_of_texture,
  output logic       out_valid,
  input  logic       out_ready,
  output rgba_t      out_first_pixel_rgba,
  output rgba_t      out_second_pixel_rgba,
  output logic       out_last_pair,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_translucency_enable
);

`include "clut4_texture_to_rgba_macros.svh"

  localparam logic [PosW-1:0] PosFull = PosW'(PalBytes);

  logic            in_fire;
  logic [PosW-1:0] pos_cur;
  logic            pal_phase;
  logic [PosW-1:0] pos_r;
  logic [PosW-1:0] pos_nxt;
  logic [7:0]      pending_low_r;
  logic            trans_en_r;
  logic            pal_we;

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  logic            s1_last_r;
  logic            s1_adv;
  color_t          color_a;
  color_t          color_b;
  rgba_t           rgba_a;
  rgba_t           rgba_b;

  logic            out_valid_r;
  logic            out_valid_nxt;
  rgba_t           out_first_r;
  rgba_t           out_second_r;
  logic            out_last_r;

  // Configuration register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_en_r <= 1'b0;
    end else if (cfg_valid) begin
      trans_en_r <= cfg_translucency_enable;
    end
  end

  // Byte counter: a start flag restarts it, and it saturates at the palette size.
  assign in_fire   = in_valid && in_ready;
  assign pos_cur   = in_start_of_texture ? '0 : pos_r;
  assign pal_phase = (pos_cur < PosFull);
  assign pos_nxt   = pal_phase ? pos_cur + 1'b1 : PosFull;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_fire) begin
      pos_r <= pos_nxt;
    end
  end

  // Even palette bytes are held until their high byte arrives.
  always_ff @(posedge clk) begin
    if (in_fire && pal_phase && !pos_cur[0]) begin
      pending_low_r <= in_data_byte;
    end
  end

  assign pal_we = in_fire && pal_phase && pos_cur[0];

  // Palette RAM: one entry written per odd palette byte, two entries read per index byte.
  clut4_ram #(
    .WIDTH (ColorW),
    .DEPTH (PalEntries)
  ) u_pal_ram (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (pos_cur[PalAddrW:1]),
    .wdata   ({in_data_byte, pending_low_r}),
    .re      (in_fire && !pal_phase),
    .raddr_a (in_data_byte[PalAddrW-1:0]),
    .raddr_b (in_data_byte[7:8-PalAddrW]),
    .rdata_a (color_a),
    .rdata_b (color_b)
  );

  // Lookup stage: valid while the RAM read data belong to a pending pixel pair.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = !pal_phase;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !pal_phase) begin
      s1_last_r <= in_end_of_texture;
    end
  end

  // Color conversion for both pixels of the pair.
  clut4_color u_color_a (
    .color               (color_a),
    .translucency_enable (trans_en_r),
    .rgba                (rgba_a)
  );

  clut4_color u_color_b (
    .color               (color_b),
    .translucency_enable (trans_en_r),
    .rgba                (rgba_b)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_first_r  <= rgba_a;
      out_second_r <= rgba_b;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_first_pixel_rgba  = out_first_r;
  assign out_second_pixel_rgba = out_second_r;
  assign out_last_pair         = out_last_r;

  // Checks on the counter and the pipeline bookkeeping.
  `CLUT4_ASSERT_IMPL(a_pos_sat, 1'b1, pos_r <= PosFull, "byte count beyond palette size")
  `CLUT4_ASSERT_NEXT(a_pal_no_res, in_fire && pal_phase, !s1_valid_r, "palette byte made a result")
  `CLUT4_ASSERT_NEXT(a_idx_res, in_fire && !pal_phase, s1_valid_r, "index byte lost in lookup")
  `CLUT4_ASSERT_NEXT(a_s1_to_out, s1_adv, out_valid_r, "pixel pair lost before output")

endmodule

// ===== sim/tb_clut4_texture_to_rgba.sv =====
// Self-checking testbench for the CLUT4 texture decoder with a built-in pixel predictor.
module tb_clut4_texture_to_rgba
  import clut4_pkg::*;
;

  localparam int RANDOM_BYTES    = 400;
  localparam int RANDOM_PHASES   = 5;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PRESSURE_CYCLES = 150;
  localparam int PRESSURE_AFTER  = 40;
  localparam int RUN_LIMIT       = 4000000;

  typedef enum logic {ROW_PALETTE, ROW_INDEX} row_kind_e;

  // One decoded index byte: two pixels and the end marker.
  typedef struct packed {
    rgba_t first;
    rgba_t second;
    logic  last;
  } pixel_pair_t;

  // A palette row sends the first "value" bytes of the directed palette;
  // an index row sends "value" itself as one index byte.
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] value;
    logic       sof;
    logic       eof;
    logic       trans;
    logic       known;
    rgba_t      first;
    rgba_t      second;
    logic       last;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = '0;
  logic       in_start_of_texture = 1'b0;
  logic       in_end_of_texture = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  rgba_t      out_first_pixel_rgba;
  rgba_t      out_second_pixel_rgba;
  logic       out_last_pair;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_translucency_enable = 1'b0;

  // Predictor state: palette copy, byte count, held low byte and register.
  color_t          pal_mirror [PalEntries];
  logic [PosW-1:0] byte_pos = '0;
  logic [7:0]      low_byte_hold = '0;
  logic            trans_en = 1'b0;

  pixel_pair_t pending_pairs [$];
  int          error_count = 0;
  int          pixel_pairs_seen = 0;
  int          bytes_sent = 0;

  // Directed palette: zero, all ones, each channel alone, alpha bit alone, small values.
  color_t directed_palette [PalEntries] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h001F, 16'h03E0, 16'h7C00, 16'h0001,
    16'h0010, 16'h5555, 16'hAAAA, 16'h1234, 16'h8421, 16'hC0DE, 16'h3E0F, 16'hFEDC
  };

  stim_row_t directed_rows [17] = '{
    // Full palette load; the end flag on its last byte must be ignored.
    '{ROW_PALETTE, 8'd32, 1'b1, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
    '{ROW_INDEX, 8'h10, 1'b0, 1'b0, 1'b0, 1'b1, 32'h00000000, 32'hFFFFFFFF, 1'b0},
    '{ROW_INDEX, 8'h32, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFFFFFF, 32'h000000FF, 1'b0},
    '{ROW_INDEX, 8'h54, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFF0000FF, 32'h00FF00FF, 1'b0},
    '{ROW_INDEX, 8'h76, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000FFFF, 32'h080000FF, 1'b0},
    '{ROW_INDEX, 8'hF8, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0},
    '{ROW_INDEX, 8'hDC, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0},
    '{ROW_INDEX, 8'hBA, 1'b0, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
    // Bytes after the end marker without a start keep decoding.
    '{ROW_INDEX, 8'h9E, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0},
    '{ROW_INDEX, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0},
    '{ROW_INDEX, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 32'h00000000, 32'h00000000, 1'b0},
    // Translucency on: the alpha bit gives half alpha.
    '{ROW_INDEX, 8'h31, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFFFF7F, 32'h0000007F, 1'b1},
    '{ROW_INDEX, 8'h5D, 1'b0, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0},
    // Restart in the index phase, then restart again at an odd palette position.
    '{ROW_PALETTE, 8'd7, 1'b1, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0},
    '{ROW_PALETTE, 8'd32, 1'b1, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0},
    '{ROW_INDEX, 8'h1E, 1'b0, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0},
    '{ROW_INDEX, 8'h03, 1'b0, 1'b1, 1'b0, 1'b1, 32'h000000FF, 32'h00000000, 1'b1}
  };

  clut4_texture_to_rgba i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_data_byte            (in_data_byte),
    .in_start_of_texture     (in_start_of_texture),
    .in_end_of_texture       (in_end_of_texture),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_first_pixel_rgba    (out_first_pixel_rgba),
    .out_second_pixel_rgba   (out_second_pixel_rgba),
    .out_last_pair           (out_last_pair),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_translucency_enable (cfg_translucency_enable)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Widen a 5-bit channel by repeating its top bits.
  function automatic logic [7:0] widen_channel(logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic rgba_t color_to_pixel(color_t c);
    logic [7:0] alpha;
    if (c == '0) return '0;
    alpha = (c[15] && trans_en) ? AlphaTrans : AlphaOpaque;
    return {widen_channel(c[4:0]), widen_channel(c[9:5]), widen_channel(c[14:10]), alpha};
  endfunction

  // Advance the predicted decoder by one byte; returns 1 when a pixel pair is due.
  function automatic bit decode_byte(logic [7:0] data, logic sof, logic eof,
                                     output pixel_pair_t pair);
    pair = '0;
    if (sof) byte_pos = '0;
    if (byte_pos < PalBytes) begin
      if (!byte_pos[0]) begin
        low_byte_hold = data;
      end else begin
        pal_mirror[byte_pos[PalAddrW:1]] = {data, low_byte_hold};
      end
      byte_pos = byte_pos + 1'b1;
      return 1'b0;
    end
    pair.first  = color_to_pixel(pal_mirror[data[3:0]]);
    pair.second = color_to_pixel(pal_mirror[data[7:4]]);
    pair.last   = eof;
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 11) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic color_t random_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h7FFF;
      default: return color_t'($urandom);
    endcase
  endfunction

  // Offer one byte, wait for its transaction, then record the predicted pair if one is due.
  task automatic send_byte(input logic [7:0] data, input logic sof, input logic eof,
                           input bit no_gaps, input bit use_typed,
                           input pixel_pair_t typed);
    int          gap;
    pixel_pair_t pair;
    gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data_byte        <= data;
    in_start_of_texture <= sof;
    in_end_of_texture   <= eof;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (decode_byte(data, sof, eof, pair)) begin
      pending_pairs.push_back(use_typed ? typed : pair);
    end
  endtask

  // Let every outstanding pair arrive and the pipeline settle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_translucency(input logic enable);
    cfg_valid               <= 1'b1;
    cfg_translucency_enable <= enable;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trans_en = enable;
  endtask

  // One random texture: mostly well formed, sometimes cut short or plain noise.
  task automatic send_random_texture();
    int     kind;
    int     count;
    bit     burst;
    color_t c;
    kind  = $urandom_range(0, 9);
    burst = ($urandom_range(0, 4) == 0);
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    if (kind <= 7) begin
      // Palette, possibly restarted before it is complete.
      for (int e = 0; e < PalEntries; e++) begin
        if (kind == 7 && e == count % PalEntries) return;
        c = random_color();
        send_byte(c[7:0], e == 0, $urandom_range(0, 15) == 0, burst, 1'b0, '0);
        send_byte(c[15:8], 1'b0, $urandom_range(0, 15) == 0, burst, 1'b0, '0);
      end
      for (int k = 0; k < count; k++) begin
        send_byte(8'($urandom), 1'b0, k == count - 1 || (kind == 6 && k == count / 2),
                  burst, 1'b0, '0);
      end
    end else if (kind == 8) begin
      // Further bytes with no start flag, end markers scattered.
      for (int k = 0; k < count; k++) begin
        send_byte(8'($urandom), 1'b0, $urandom_range(0, 3) == 0, burst, 1'b0, '0);
      end
    end else begin
      // Noise with stray start and end flags.
      for (int k = 0; k < count; k++) begin
        send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                  burst, 1'b0, '0);
      end
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %08h, got %08h", field, want, got);
      error_count++;
    end
  endtask

  // Compare each pixel pair transaction with the oldest prediction.
  always @(posedge clk) begin : pair_checker
    pixel_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      pixel_pairs_seen++;
      if (pending_pairs.size() == 0) begin
        $error("unexpected pixel pair: %08h %08h last %0b",
               out_first_pixel_rgba, out_second_pixel_rgba, out_last_pair);
        error_count++;
      end else begin
        want = pending_pairs.pop_front();
        check_field("first_pixel_rgba", want.first, out_first_pixel_rgba);
        check_field("second_pixel_rgba", want.second, out_second_pixel_rgba);
        check_field("last_pair", 32'(want.last), 32'(out_last_pair));
      end
    end
  end

  // Receiver: random stalls and ready stretches, plus one long hold-off to fill the block.
  initial begin : out_ready_gen
    int  hold;
    bit  pressure_done;
    pressure_done = 1'b0;
    @(posedge clk);
    forever begin
      if (!pressure_done && pixel_pairs_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        hold = PRESSURE_CYCLES;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        hold = pick_gap();
      end else begin
        out_ready <= 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
      end
      repeat (hold) @(posedge clk);
    end
  end

  // Main sequence: reset, directed table, then random phases at alternating settings.
  initial begin : stimulus
    stim_row_t row;
    color_t    c;
    int        phase_end;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < $size(directed_rows); r++) begin
      row = directed_rows[r];
      if (row.trans != trans_en) begin
        drain_pipeline();
        write_translucency(row.trans);
      end
      if (row.kind == ROW_PALETTE) begin
        for (int k = 0; k < row.value; k++) begin
          c = directed_palette[k / 2];
          send_byte(k[0] ? c[15:8] : c[7:0], row.sof && k == 0,
                    row.eof && k == row.value - 1, 1'b0, 1'b0, '0);
        end
      end else begin
        send_byte(row.value, row.sof, row.eof, 1'b0, row.known,
                  '{row.first, row.second, row.last});
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_pipeline();
      write_translucency(phase % 2 == 0);
      phase_end = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
      while (bytes_sent < phase_end) send_random_texture();
    end

    drain_pipeline();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin : run_limit
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/clut4_pkg.sv
design/clut4_ram.sv
design/clut4_color.sv
design/clut4_texture_to_rgba.sv
sim/tb_clut4_texture_to_rgba.sv
